// ----- rtl/core/ctjt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctjt_pkg
// Shared constants, types and the raised-cosine table function of the
// cosine joint trajectory unit.
// ----------------------------------------------------------------------------
package ctjt_pkg;

  localparam int JOINT_COUNT        = 7;
  localparam int JOINT_SLOTS        = 7;
  localparam int SMOOTH_TABLE_DEPTH = 1024;

  localparam int JOINT_W   = 23;
  localparam int PERIOD_W  = 17;
  localparam int ELAPSED_W = 32;
  localparam int DUR_W     = 26;
  localparam int FRAC_W    = 16;
  localparam int SMOOTH_W  = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = DUR_W;

  localparam logic [DUR_W-1:0]    DUR_RESET = DUR_W'(5000000);
  localparam logic [SMOOTH_W-1:0] ONE_Q16   = SMOOTH_W'(65536);
  localparam logic [63:0]         PI_Q30    = 64'd3373259426;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = CFG_IDX_W'(7);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_ROM,
    S_MUL,
    S_SUM,
    S_OUT
  } state_t;

  typedef struct packed {
    logic latch;
    logic diff_en;
    logic mul_en;
    logic sum_en;
  } lane_ctl_t;

  typedef struct packed {
    logic              full;
    logic [FRAC_W-1:0] frac;
  } prog_t;

  // Q0.16 of 0.5 - 0.5 cos(theta) for theta in Q30, by an eight-term series.
  function automatic logic [SMOOTH_W-1:0] smooth_half(input logic [63:0] theta);
    logic [63:0]        t;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rnd;
    t    = (theta * theta) >> 30;
    term = t >> 1;
    sum  = $signed(term);
    term = ((term * t) >> 30) / 64'd12;
    sum  = sum - $signed(term);
    term = ((term * t) >> 30) / 64'd30;
    sum  = sum + $signed(term);
    term = ((term * t) >> 30) / 64'd56;
    sum  = sum - $signed(term);
    term = ((term * t) >> 30) / 64'd90;
    sum  = sum + $signed(term);
    term = ((term * t) >> 30) / 64'd132;
    sum  = sum - $signed(term);
    term = ((term * t) >> 30) / 64'd182;
    sum  = sum + $signed(term);
    term = ((term * t) >> 30) / 64'd240;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    rnd = ($unsigned(sum) + 64'd16384) >> 15;
    return rnd[SMOOTH_W-1:0];
  endfunction

endpackage

// ----- rtl/core/cosine_joint_trajectory_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_joint_trajectory_unit
// Raised-cosine interpolation from a latched start pose to the configured
// joint targets, one command set per control tick.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one control tick (new_move, period_us and the
//   measured joints); a transfer happens when in_valid is high and in_stall
//   low. Each tick yields exactly one result on the output channel.
//   Targets and move_duration_us are written through cfg_we / cfg_index /
//   cfg_data while no tick is in flight.
// Sequencing:
//   A tick runs through the states START, DIV, ROM, MUL, SUM and OUT after its
//   input transfer. In DIV the 16-step progress divider works while the move is
//   running; its steps are skipped once the elapsed time has reached the duration.
//   in_stall is high while a tick is being worked on, until it leaves OUT.
// Reset:
//   rst_n clears start pose and elapsed time, targets to zero, the duration
//   to 5000000 us, and empties the output register.
// Output stall:
//   The result waits in the output register while out_stall is high; the
//   next tick is accepted meanwhile and then waits before its last step.
// ----------------------------------------------------------------------------
module cosine_joint_trajectory_unit #(
  parameter int JointCount       = ctjt_pkg::JOINT_COUNT,
  parameter int SmoothTableDepth = ctjt_pkg::SMOOTH_TABLE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [ctjt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ctjt_pkg::CFG_W-1:0]           cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_new_move,
  input  logic [ctjt_pkg::PERIOD_W-1:0]        in_period_us,
  input  logic signed [ctjt_pkg::JOINT_W-1:0]  in_measured_joint_0,
  input  logic signed [ctjt_pkg::JOINT_W-1:0]  in_measured_joint_1,
  input  logic signed [ctjt_pkg::JOINT_W-1:0]  in_measured_joint_2,
  input  logic signed [ctjt_pkg::JOINT_W-1:0]  in_measured_joint_3,
  input  logic signed [ctjt_pkg::JOINT_W-1:0]  in_measured_joint_4,
  input  logic signed [ctjt_pkg::JOINT_W-1:0]  in_measured_joint_5,
  input  logic signed [ctjt_pkg::JOINT_W-1:0]  in_measured_joint_6,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ctjt_pkg::JOINT_W-1:0]  out_command_joint_0,
  output logic signed [ctjt_pkg::JOINT_W-1:0]  out_command_joint_1,
  output logic signed [ctjt_pkg::JOINT_W-1:0]  out_command_joint_2,
  output logic signed [ctjt_pkg::JOINT_W-1:0]  out_command_joint_3,
  output logic signed [ctjt_pkg::JOINT_W-1:0]  out_command_joint_4,
  output logic signed [ctjt_pkg::JOINT_W-1:0]  out_command_joint_5,
  output logic signed [ctjt_pkg::JOINT_W-1:0]  out_command_joint_6,
  output logic                                 out_finished
);

  localparam int JW    = ctjt_pkg::JOINT_W;
  localparam int EW    = ctjt_pkg::ELAPSED_W;
  localparam int NS    = ctjt_pkg::JOINT_SLOTS;
  localparam int FW    = ctjt_pkg::FRAC_W;
  localparam int IdxW  = $clog2(SmoothTableDepth);
  localparam int MulW  = FW + $clog2(SmoothTableDepth + 1);

  ctjt_pkg::state_t    state_r, state_nxt;
  ctjt_pkg::lane_ctl_t lane_ctl;
  ctjt_pkg::prog_t     prog;

  logic signed [JW-1:0]            target_r [NS];
  logic [ctjt_pkg::DUR_W-1:0]      duration_r;
  logic [EW-1:0]                   elapsed_r;
  logic [EW-1:0]                   elapsed_base;
  logic [EW:0]                     elapsed_sum;
  logic                            in_xfer;
  logic                            div_start;
  logic                            div_done;
  logic                            out_load;
  logic [MulW-1:0]                 idx_prod;
  logic [IdxW-1:0]                 rom_addr;
  logic [ctjt_pkg::SMOOTH_W-1:0]   rom_data;
  logic [ctjt_pkg::SMOOTH_W-1:0]   smooth;
  logic signed [JW-1:0]            measured [NS];
  logic signed [JW-1:0]            lane_cmd [NS];
  logic signed [JW-1:0]            out_cmd_r [NS];
  logic                            out_fin_r;
  logic                            out_valid_r;

  assign measured[0] = in_measured_joint_0;
  assign measured[1] = in_measured_joint_1;
  assign measured[2] = in_measured_joint_2;
  assign measured[3] = in_measured_joint_3;
  assign measured[4] = in_measured_joint_4;
  assign measured[5] = in_measured_joint_5;
  assign measured[6] = in_measured_joint_6;

  assign in_xfer = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NS; j++) begin
        target_r[j] <= '0;
      end
      duration_r <= ctjt_pkg::DUR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == ctjt_pkg::REG_DURATION) begin
        duration_r <= cfg_data;
      end else begin
        target_r[cfg_index] <= cfg_data[JW-1:0];
      end
    end
  end

  // Elapsed time restarts on a new move and saturates instead of wrapping.
  assign elapsed_base = in_new_move ? '0 : elapsed_r;
  assign elapsed_sum  = {1'b0, elapsed_base} + (EW + 1)'(in_period_us);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else if (in_xfer) begin
      elapsed_r <= elapsed_sum[EW] ? '1 : elapsed_sum[EW-1:0];
    end
  end

  ctjt_progress_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .elapsed  (elapsed_r),
    .duration (duration_r),
    .prog     (prog),
    .done     (div_done)
  );

  // Table index is floor(p * depth / 2^16) for p below one.
  assign idx_prod = MulW'(prog.frac) * MulW'(SmoothTableDepth);
  assign rom_addr = idx_prod[FW +: IdxW];

  ctjt_smooth_rom #(
    .Depth (SmoothTableDepth)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  assign smooth = prog.full ? ctjt_pkg::ONE_Q16 : rom_data;

  for (genvar j = 0; j < NS; j++) begin : g_lane
    if (j < JointCount) begin : g_on
      ctjt_lane u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (lane_ctl),
        .measured (measured[j]),
        .target   (target_r[j]),
        .smooth   (smooth),
        .command  (lane_cmd[j])
      );
    end else begin : g_off
      assign lane_cmd[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctjt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    in_stall         = 1'b1;
    div_start        = 1'b0;
    out_load         = 1'b0;
    lane_ctl.latch   = 1'b0;
    lane_ctl.diff_en = 1'b0;
    lane_ctl.mul_en  = 1'b0;
    lane_ctl.sum_en  = 1'b0;
    case (state_r)
      ctjt_pkg::S_IDLE: begin
        in_stall       = 1'b0;
        lane_ctl.latch = in_valid && in_new_move;
        if (in_valid) begin
          state_nxt = ctjt_pkg::S_START;
        end
      end
      ctjt_pkg::S_START: begin
        div_start        = 1'b1;
        lane_ctl.diff_en = 1'b1;
        state_nxt        = ctjt_pkg::S_DIV;
      end
      ctjt_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = ctjt_pkg::S_ROM;
        end
      end
      ctjt_pkg::S_ROM: begin
        state_nxt = ctjt_pkg::S_MUL;
      end
      ctjt_pkg::S_MUL: begin
        lane_ctl.mul_en = 1'b1;
        state_nxt       = ctjt_pkg::S_SUM;
      end
      ctjt_pkg::S_SUM: begin
        lane_ctl.sum_en = 1'b1;
        state_nxt       = ctjt_pkg::S_OUT;
      end
      ctjt_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ctjt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ctjt_pkg::S_IDLE;
      end
    endcase
  end

  // Output register gathers the lane results for the transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int j = 0; j < NS; j++) begin
        out_cmd_r[j] <= lane_cmd[j];
      end
      out_fin_r <= prog.full;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_command_joint_0 = out_cmd_r[0];
  assign out_command_joint_1 = out_cmd_r[1];
  assign out_command_joint_2 = out_cmd_r[2];
  assign out_command_joint_3 = out_cmd_r[3];
  assign out_command_joint_4 = out_cmd_r[4];
  assign out_command_joint_5 = out_cmd_r[5];
  assign out_command_joint_6 = out_cmd_r[6];
  assign out_finished        = out_fin_r;

endmodule

// ----- rtl/core/ctjt_progress_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctjt_progress_div
// Progress unit: min(elapsed * 2^16 / duration, 1) in Q0.16, one quotient
// bit per cycle by restoring division.
// ----------------------------------------------------------------------------
module ctjt_progress_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ctjt_pkg::ELAPSED_W-1:0] elapsed,
  input  logic [ctjt_pkg::DUR_W-1:0]     duration,
  output ctjt_pkg::prog_t                prog,
  output logic                           done
);

  localparam int DW = ctjt_pkg::DUR_W;
  localparam int FW = ctjt_pkg::FRAC_W;
  localparam int CW = $clog2(FW);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [FW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          full_r;
  logic          done_r;
  logic [DW:0]   rem2;
  logic          ge;

  assign rem2    = {rem_r, 1'b0};
  assign ge      = rem2 >= {1'b0, duration};
  assign rem_nxt = ge ? DW'(rem2 - {1'b0, duration}) : rem2[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // Elapsed at or past the duration (or a zero duration) ends the move.
        if (elapsed >= ctjt_pkg::ELAPSED_W'(duration)) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(FW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      full_r <= elapsed >= ctjt_pkg::ELAPSED_W'(duration);
      rem_r  <= elapsed[DW-1:0];
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[FW-2:0], ge};
    end
  end

  assign prog.full = full_r;
  assign prog.frac = quo_r;
  assign done      = done_r;

endmodule

// ----- rtl/core/ctjt_smooth_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctjt_smooth_rom
// Raised-cosine table, 0.5 - 0.5 cos(pi * k / depth) in Q0.16, with a
// registered read.
// ----------------------------------------------------------------------------
module ctjt_smooth_rom #(
  parameter int Depth = ctjt_pkg::SMOOTH_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic [$clog2(Depth)-1:0]      addr,
  output logic [ctjt_pkg::SMOOTH_W-1:0] data
);

  localparam int SW = ctjt_pkg::SMOOTH_W;

  logic [SW-1:0] rom [Depth];
  logic [SW-1:0] data_r;

  // The second half mirrors the first around one half.
  for (genvar k = 0; k < Depth; k++) begin : g_ent
    localparam bit           Lower = (2 * k <= Depth);
    localparam int unsigned  Kk    = Lower ? k : Depth - k;
    localparam logic [63:0]  Theta = (ctjt_pkg::PI_Q30 * 64'(Kk)) / 64'(Depth);
    localparam logic [SW-1:0] Half = ctjt_pkg::smooth_half(Theta);
    assign rom[k] = Lower ? Half : SW'(ctjt_pkg::ONE_Q16 - Half);
  end

  always_ff @(posedge clk) begin
    data_r <= rom[addr];
  end

  assign data = data_r;

endmodule

// ----- rtl/core/ctjt_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctjt_lane
// One joint: holds the start pose and forms start + smooth * (target - start)
// scaled down by 2^16 with a floor.
// ----------------------------------------------------------------------------
module ctjt_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ctjt_pkg::lane_ctl_t                 ctl,
  input  logic signed [ctjt_pkg::JOINT_W-1:0] measured,
  input  logic signed [ctjt_pkg::JOINT_W-1:0] target,
  input  logic [ctjt_pkg::SMOOTH_W-1:0]       smooth,
  output logic signed [ctjt_pkg::JOINT_W-1:0] command
);

  localparam int JW = ctjt_pkg::JOINT_W;
  localparam int SW = ctjt_pkg::SMOOTH_W;
  localparam int PW = JW + 1 + SW + 1;

  logic signed [JW-1:0] start_r;
  logic signed [JW:0]   diff_r;
  logic signed [JW-1:0] scaled_r;
  logic signed [JW-1:0] cmd_r;
  logic signed [PW-1:0] prod;

  assign prod = $signed({1'b0, smooth}) * diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
    end else if (ctl.latch) begin
      start_r <= measured;
    end
  end

  // Only the low bits of the floored product matter after the final wrap.
  always_ff @(posedge clk) begin
    if (ctl.diff_en) begin
      diff_r <= (JW + 1)'(target) - (JW + 1)'(start_r);
    end
    if (ctl.mul_en) begin
      scaled_r <= prod[16 +: JW];
    end
    if (ctl.sum_en) begin
      cmd_r <= start_r + scaled_r;
    end
  end

  assign command = cmd_r;

endmodule
